// ----- hw/rtl/iri_pkg.sv -----
// Shared constants and types for the image resize interpolator.
// Field widths, configuration register indexes and queue entry kind codes.
// No dependencies.
`default_nettype none

package iri_pkg;

    localparam int COORD_W     = 12;
    localparam int STEP_W      = 25;
    localparam int DIM_W       = 9;
    localparam int FRAC_W      = 16;
    localparam int IN_PIX_W    = 8;
    localparam int OUT_PIX_W   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESIZE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP      = 3'd4;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    localparam logic              RST_MODE = MODE_BILINEAR;
    localparam logic [DIM_W-1:0]  RST_DIM  = 9'd256;
    localparam logic [STEP_W-1:0] RST_STEP = 25'd65536;

    // unity weight in 1.16 fixed point, one bit wider than a fraction
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_LOAD      = 2'd0;
    localparam t_kind KIND_COMPUTE   = 2'd1;
    localparam t_kind KIND_RANGE_ERR = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/image_resize_interpolator.sv -----
// Image resize interpolator: nearest-neighbor or bilinear resampling of a stored image.
//
// Channels: input transactions (i_in_valid/o_in_ready) carry a request type, row,
// column and pixel. A load writes one source pixel and returns nothing; loads
// outside the store are dropped. A compute returns one output transaction
// (o_out_valid/i_out_ready) with the pixel and a range error flag. The config
// port (i_cfg_valid/o_cfg_ready, index, data) is always ready; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Flow: an accepted transaction passes through the front-end stage register into
// the queue, and the back end pops it when idle. A compute runs four reads from
// the single-port frame store feeding one shared multiplier, then the vertical
// blend steps, then waits in the done state for the output register. A load
// writes the store as it is popped; a range error goes straight to the done state.
// A 4-entry queue lets the front end keep taking transactions meanwhile.
// Reset: registers return to bilinear, 256x256, unity steps; the queue and the
// output register empty. The frame store is not cleared.
// Stall: a held result stays in the output register; the back end finishes the
// next item and waits, then the queue and finally o_in_ready back up.
// Depends on iri_pkg, iri_front, iri_fifo, iri_back.
`default_nettype none

module image_resize_interpolator #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iri_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [iri_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [iri_pkg::COORD_W-1:0]     i_row_index,
    input  logic [iri_pkg::COORD_W-1:0]     i_col_index,
    input  logic [iri_pkg::IN_PIX_W-1:0]    i_pixel_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [iri_pkg::OUT_PIX_W-1:0]   o_pixel_out,
    output logic                            o_range_error
);

    localparam int AW    = $clog2(MAX_DIM);
    localparam int ENT_W = $bits(iri_pkg::t_kind) + 4 * AW + 2 * iri_pkg::FRAC_W + PIXEL_BITS;

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    logic [ENT_W-1:0] entry;
    logic [ENT_W-1:0] head;

    assign o_cfg_ready = 1'b1;

    iri_front #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_pixel_in  (i_pixel_in),
        .o_push      (push),
        .o_entry     (entry),
        .i_full      (full)
    );

    iri_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    iri_back #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_range_error (o_range_error)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/iri_front.sv -----
// Front end: configuration registers, input acceptance and item classification.
// Projects output coordinates into source space and builds queue entries.
// Depends on iri_pkg.
`default_nettype none

module iri_front #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 8,
    localparam int AW    = $clog2(MAX_DIM),
    localparam int ENT_W = $bits(iri_pkg::t_kind) + 4 * AW + 2 * iri_pkg::FRAC_W + PIXEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [iri_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [iri_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [iri_pkg::COORD_W-1:0]     i_row_index,
    input  logic [iri_pkg::COORD_W-1:0]     i_col_index,
    input  logic [iri_pkg::IN_PIX_W-1:0]    i_pixel_in,
    output logic                            o_push,
    output logic [ENT_W-1:0]                o_entry,
    input  logic                            i_full
);

    localparam int POS_W   = iri_pkg::COORD_W + iri_pkg::STEP_W;
    localparam int FLOOR_W = POS_W - iri_pkg::FRAC_W;
    localparam int MD_W    = $clog2(MAX_DIM + 1);
    localparam int EDW     = (MD_W > iri_pkg::DIM_W) ? MD_W : iri_pkg::DIM_W;
    localparam int LW      = iri_pkg::COORD_W + 1;

    typedef struct packed {
        iri_pkg::t_kind                kind;
        logic [AW-1:0]                 row_lo;
        logic [AW-1:0]                 row_hi;
        logic [AW-1:0]                 col_lo;
        logic [AW-1:0]                 col_hi;
        logic [iri_pkg::FRAC_W-1:0]    frac_row;
        logic [iri_pkg::FRAC_W-1:0]    frac_col;
        logic [PIXEL_BITS-1:0]         pixel;
    } t_entry;

    logic                             r_mode;
    logic [iri_pkg::DIM_W-1:0]        r_src_w;
    logic [iri_pkg::DIM_W-1:0]        r_src_h;
    logic [iri_pkg::STEP_W-1:0]       r_col_step;
    logic [iri_pkg::STEP_W-1:0]       r_row_step;

    logic                             r_vld;
    logic                             r_req;
    logic [iri_pkg::COORD_W-1:0]      r_row;
    logic [iri_pkg::COORD_W-1:0]      r_col;
    logic [iri_pkg::IN_PIX_W-1:0]     r_pix;
    logic [POS_W-1:0]                 r_py;
    logic [POS_W-1:0]                 r_px;

    logic                             accept;
    logic                             advance;
    logic [EDW-1:0]                   eff_w;
    logic [EDW-1:0]                   eff_h;
    logic [FLOOR_W-1:0]               floor_y;
    logic [FLOOR_W-1:0]               floor_x;
    logic [iri_pkg::FRAC_W-1:0]       frac_y;
    logic [iri_pkg::FRAC_W-1:0]       frac_x;
    logic                             range_err;
    logic                             blend_y;
    logic                             blend_x;
    logic                             load_ok;
    t_entry                           ent;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= iri_pkg::RST_MODE;
            r_src_w    <= iri_pkg::RST_DIM;
            r_src_h    <= iri_pkg::RST_DIM;
            r_col_step <= iri_pkg::RST_STEP;
            r_row_step <= iri_pkg::RST_STEP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                iri_pkg::CFG_RESIZE_MODE:   r_mode     <= i_cfg_data[0];
                iri_pkg::CFG_SOURCE_WIDTH:  r_src_w    <= i_cfg_data[iri_pkg::DIM_W-1:0];
                iri_pkg::CFG_SOURCE_HEIGHT: r_src_h    <= i_cfg_data[iri_pkg::DIM_W-1:0];
                iri_pkg::CFG_COLUMN_STEP:   r_col_step <= i_cfg_data[iri_pkg::STEP_W-1:0];
                iri_pkg::CFG_ROW_STEP:      r_row_step <= i_cfg_data[iri_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_vld || !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign advance    = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (advance) begin
            r_vld <= 1'b0;
        end
    end

    // projection multiply happens on the way into the stage register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_row <= i_row_index;
            r_col <= i_col_index;
            r_pix <= i_pixel_in;
            r_py  <= POS_W'(i_row_index) * POS_W'(r_row_step);
            r_px  <= POS_W'(i_col_index) * POS_W'(r_col_step);
        end
    end

    always_comb begin
        eff_w = (EDW'(r_src_w) > EDW'(MAX_DIM)) ? EDW'(MAX_DIM) : EDW'(r_src_w);
        eff_h = (EDW'(r_src_h) > EDW'(MAX_DIM)) ? EDW'(MAX_DIM) : EDW'(r_src_h);

        floor_y = r_py[POS_W-1:iri_pkg::FRAC_W];
        floor_x = r_px[POS_W-1:iri_pkg::FRAC_W];
        frac_y  = r_py[iri_pkg::FRAC_W-1:0];
        frac_x  = r_px[iri_pkg::FRAC_W-1:0];

        range_err = (floor_y >= FLOOR_W'(eff_h)) || (floor_x >= FLOOR_W'(eff_w));

        // an axis blends only if its ceiling neighbor survives the clamp
        blend_y = (r_mode == iri_pkg::MODE_BILINEAR) && (frac_y != '0)
                  && ((floor_y + FLOOR_W'(1)) < FLOOR_W'(eff_h));
        blend_x = (r_mode == iri_pkg::MODE_BILINEAR) && (frac_x != '0)
                  && ((floor_x + FLOOR_W'(1)) < FLOOR_W'(eff_w));

        load_ok = ({1'b0, r_row} < LW'(MAX_DIM)) && ({1'b0, r_col} < LW'(MAX_DIM));

        ent.pixel = PIXEL_BITS'(r_pix);
        if (r_req == iri_pkg::REQ_LOAD) begin
            ent.kind     = iri_pkg::KIND_LOAD;
            ent.row_lo   = r_row[AW-1:0];
            ent.row_hi   = r_row[AW-1:0];
            ent.col_lo   = r_col[AW-1:0];
            ent.col_hi   = r_col[AW-1:0];
            ent.frac_row = '0;
            ent.frac_col = '0;
        end else begin
            ent.kind     = range_err ? iri_pkg::KIND_RANGE_ERR : iri_pkg::KIND_COMPUTE;
            ent.row_lo   = floor_y[AW-1:0];
            ent.row_hi   = blend_y ? AW'(floor_y[AW-1:0] + AW'(1)) : floor_y[AW-1:0];
            ent.col_lo   = floor_x[AW-1:0];
            ent.col_hi   = blend_x ? AW'(floor_x[AW-1:0] + AW'(1)) : floor_x[AW-1:0];
            ent.frac_row = blend_y ? frac_y : '0;
            ent.frac_col = blend_x ? frac_x : '0;
        end
    end

    // loads outside the store are dropped here
    assign o_push  = advance && ((r_req == iri_pkg::REQ_COMPUTE) || load_ok);
    assign o_entry = ent;

endmodule

`default_nettype wire

// ----- hw/rtl/iri_fifo.sv -----
// Short entry queue between the front end and the back end.
// Register array with read and write pointers and an occupancy count.
// Depends on iri_pkg.
`default_nettype none

module iri_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = iri_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/iri_back.sv -----
// Back end: frame store, neighbor read sequencer, blend datapath, output register.
// One single-port store and one shared multiplier serve all four taps.
// Depends on iri_pkg.
`default_nettype none

module iri_back #(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 8,
    localparam int AW    = $clog2(MAX_DIM),
    localparam int ENT_W = $bits(iri_pkg::t_kind) + 4 * AW + 2 * iri_pkg::FRAC_W + PIXEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  logic [ENT_W-1:0]               i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [iri_pkg::OUT_PIX_W-1:0]  o_pixel_out,
    output logic                           o_range_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int MW    = $clog2(DEPTH);
    localparam int FW    = iri_pkg::FRAC_W;
    localparam int MA_W  = PIXEL_BITS + FW;
    localparam int MB_W  = FW + 1;
    localparam int PR_W  = MA_W + MB_W;
    localparam int ACC_W = PIXEL_BITS + 2 * FW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // sequencer steps: four reads with the x blends trailing them, then the y blend
    localparam logic [2:0] STEP_V1     = 3'd0;
    localparam logic [2:0] STEP_V2     = 3'd1;
    localparam logic [2:0] STEP_V3     = 3'd2;
    localparam logic [2:0] STEP_V4     = 3'd3;
    localparam logic [2:0] STEP_LAST_X = 3'd4;
    localparam logic [2:0] STEP_WY0    = 3'd5;
    localparam logic [2:0] STEP_WY1    = 3'd6;

    typedef struct packed {
        iri_pkg::t_kind                kind;
        logic [AW-1:0]                 row_lo;
        logic [AW-1:0]                 row_hi;
        logic [AW-1:0]                 col_lo;
        logic [AW-1:0]                 col_hi;
        logic [FW-1:0]                 frac_row;
        logic [FW-1:0]                 frac_col;
        logic [PIXEL_BITS-1:0]         pixel;
    } t_entry;

    function automatic logic [MW-1:0] addr_of(input logic [AW-1:0] row,
                                              input logic [AW-1:0] col);
        addr_of = MW'(MW'(row) * MW'(MAX_DIM) + MW'(col));
    endfunction

    logic [PIXEL_BITS-1:0]           r_store [DEPTH];
    logic [PIXEL_BITS-1:0]           r_rdata;

    logic [1:0]                      r_state;
    logic [2:0]                      r_step;
    t_entry                          r_ent;
    logic [MA_W-1:0]                 r_q;
    logic [MA_W-1:0]                 r_q1;
    logic [ACC_W-1:0]                r_acc;
    logic [PIXEL_BITS-1:0]           r_res;
    logic                            r_err;
    logic                            r_out_valid;
    logic [iri_pkg::OUT_PIX_W-1:0]   r_pixel_out;
    logic                            r_range_error;

    t_entry                          head;
    logic                            mem_we;
    logic [MW-1:0]                   mem_addr;
    logic [AW-1:0]                   rd_row;
    logic [AW-1:0]                   rd_col;
    logic [MB_W-1:0]                 wx0;
    logic [MB_W-1:0]                 wx1;
    logic [MB_W-1:0]                 wy0;
    logic [MB_W-1:0]                 wy1;
    logic [MA_W-1:0]                 mul_a;
    logic [MB_W-1:0]                 mul_b;
    logic [PR_W-1:0]                 prod;
    logic [ACC_W-1:0]                acc_sum;
    logic                            out_free;
    logic                            done_fire;

    assign head      = t_entry'(i_head);
    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign mem_we    = o_pop && (head.kind == iri_pkg::KIND_LOAD);
    assign out_free  = !r_out_valid || i_out_ready;
    assign done_fire = (r_state == ST_DONE) && out_free;

    always_comb begin
        unique case (r_step)
            STEP_V2: begin
                rd_row = r_ent.row_lo;
                rd_col = r_ent.col_hi;
            end
            STEP_V3: begin
                rd_row = r_ent.row_hi;
                rd_col = r_ent.col_lo;
            end
            STEP_V4: begin
                rd_row = r_ent.row_hi;
                rd_col = r_ent.col_hi;
            end
            default: begin
                rd_row = r_ent.row_lo;
                rd_col = r_ent.col_lo;
            end
        endcase
        mem_addr = mem_we ? addr_of(head.row_lo, head.col_lo) : addr_of(rd_row, rd_col);
    end

    // single-port frame store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= head.pixel;
        end else begin
            r_rdata <= r_store[mem_addr];
        end
    end

    // weights; a zero fraction means the axis does not blend
    assign wx1 = {1'b0, r_ent.frac_col};
    assign wx0 = iri_pkg::FRAC_ONE - wx1;
    assign wy1 = {1'b0, r_ent.frac_row};
    assign wy0 = iri_pkg::FRAC_ONE - wy1;

    // read data for step k arrives one step later
    always_comb begin
        unique case (r_step)
            STEP_V2:     begin mul_a = MA_W'(r_rdata); mul_b = wx0; end
            STEP_V3:     begin mul_a = MA_W'(r_rdata); mul_b = wx1; end
            STEP_V4:     begin mul_a = MA_W'(r_rdata); mul_b = wx0; end
            STEP_LAST_X: begin mul_a = MA_W'(r_rdata); mul_b = wx1; end
            STEP_WY0:    begin mul_a = r_q1;           mul_b = wy0; end
            STEP_WY1:    begin mul_a = r_q;            mul_b = wy1; end
            default:     begin mul_a = '0;             mul_b = '0;  end
        endcase
        prod    = PR_W'(mul_a) * PR_W'(mul_b);
        acc_sum = r_acc + prod[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_V1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        priority if (head.kind == iri_pkg::KIND_COMPUTE) begin
                            r_state <= ST_RUN;
                            r_step  <= STEP_V1;
                        end else if (head.kind == iri_pkg::KIND_RANGE_ERR) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_step == STEP_WY1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= head;
            r_res <= '0;
            r_err <= (head.kind == iri_pkg::KIND_RANGE_ERR);
        end
        if (r_state == ST_RUN) begin
            unique case (r_step)
                STEP_V2:     r_q   <= prod[MA_W-1:0];
                STEP_V3:     r_q1  <= r_q + prod[MA_W-1:0];
                STEP_V4:     r_q   <= prod[MA_W-1:0];
                STEP_LAST_X: r_q   <= r_q + prod[MA_W-1:0];
                STEP_WY0:    r_acc <= prod[ACC_W-1:0];
                STEP_WY1:    r_res <= acc_sum[ACC_W-1:2*FW];
                default: ;
            endcase
        end
    end

    // output register: holds a result while the back end starts the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_pixel_out   <= iri_pkg::OUT_PIX_W'(r_res);
            r_range_error <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_out   = r_pixel_out;
    assign o_range_error = r_range_error;

endmodule

`default_nettype wire

// ----- hw/rtl/iri_checker.sv -----
// Port-level checks for the image resize interpolator, bound to the top level.
// Tracks outstanding compute transactions from the ports alone.
// Depends on image_resize_interpolator.
`default_nettype none

module iri_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_req_type,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [iri_pkg::OUT_PIX_W-1:0]  o_pixel_out,
    input logic                           o_range_error
);

    logic [3:0] r_pending;
    logic       cmp_acc;
    logic       out_acc;

    assign cmp_acc = i_in_valid && o_in_ready && (i_req_type == iri_pkg::REQ_COMPUTE);
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (cmp_acc && !out_acc) begin
            r_pending <= r_pending + 4'd1;
        end else if (out_acc && !cmp_acc) begin
            r_pending <= r_pending - 4'd1;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pixel_out) && $stable(o_range_error))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 4'd0)
        else $error("result without a pending compute");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_pixel_out == '0)
        else $error("range error with nonzero pixel");

endmodule

bind image_resize_interpolator iri_port_checker u_iri_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_req_type    (i_req_type),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_out   (o_pixel_out),
    .o_range_error (o_range_error)
);

`default_nettype wire

// ----- sim/iri_checker.sv -----
// Scoreboard for image_resize_interpolator: watches the config, input and output channels.
// Keeps its own registers and frame store, predicts every compute result and compares.
// Depends on iri_pkg.
module iri_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [iri_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [iri_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_req_type,
    input  logic [iri_pkg::COORD_W-1:0]    i_row_index,
    input  logic [iri_pkg::COORD_W-1:0]    i_col_index,
    input  logic [iri_pkg::IN_PIX_W-1:0]   i_pixel_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [iri_pkg::OUT_PIX_W-1:0]  i_pixel_out,
    input  logic                           i_range_error,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_range_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DIM = 256;

    typedef struct packed {
        logic [iri_pkg::OUT_PIX_W-1:0] pixel;
        logic                          range_error;
    } t_resize_result;

    logic                         resize_mode;
    logic [iri_pkg::DIM_W-1:0]    src_width;
    logic [iri_pkg::DIM_W-1:0]    src_height;
    logic [iri_pkg::STEP_W-1:0]   col_step;
    logic [iri_pkg::STEP_W-1:0]   row_step;
    logic [iri_pkg::IN_PIX_W-1:0] src_pixels [STORE_DIM*STORE_DIM];
    t_resize_result               pending_pixels [$];

    function automatic int unsigned clamp_dim(logic [iri_pkg::DIM_W-1:0] d);
        return (d > STORE_DIM) ? STORE_DIM : int'(d);
    endfunction

    function automatic logic [63:0] pixel_at(int unsigned y, int unsigned x);
        return 64'(src_pixels[y*STORE_DIM + x]);
    endfunction

    function automatic t_resize_result resample_pixel(logic [iri_pkg::COORD_W-1:0] row,
                                                      logic [iri_pkg::COORD_W-1:0] col);
        logic [63:0]    pos_y, pos_x, frac_y, frac_x, upper, lower;
        int unsigned    w, h, y0, x0, y1, x1;
        t_resize_result res;
        w = clamp_dim(src_width);
        h = clamp_dim(src_height);
        pos_y = 64'(row) * 64'(row_step);
        pos_x = 64'(col) * 64'(col_step);
        res.range_error = 1'b0;
        if ((pos_y >> 16) >= h || (pos_x >> 16) >= w) begin
            res.pixel = '0;
            res.range_error = 1'b1;
            return res;
        end
        y0 = pos_y[47:16];
        x0 = pos_x[47:16];
        frac_y = {48'd0, pos_y[15:0]};
        frac_x = {48'd0, pos_x[15:0]};
        if (resize_mode == iri_pkg::MODE_NEAREST) begin
            res.pixel = iri_pkg::OUT_PIX_W'(pixel_at(y0, x0));
        end else begin
            // an axis with no fraction or a clamped ceiling folds into full weight on
            // the floor pixel, which is exactly the unblended value
            y1 = (frac_y != 0 && y0 + 1 < h) ? y0 + 1 : y0;
            x1 = (frac_x != 0 && x0 + 1 < w) ? x0 + 1 : x0;
            upper = pixel_at(y0, x0) * (64'(iri_pkg::FRAC_ONE) - frac_x)
                    + pixel_at(y0, x1) * frac_x;
            lower = pixel_at(y1, x0) * (64'(iri_pkg::FRAC_ONE) - frac_x)
                    + pixel_at(y1, x1) * frac_x;
            res.pixel = iri_pkg::OUT_PIX_W'((upper * (64'(iri_pkg::FRAC_ONE) - frac_y)
                                             + lower * frac_y) >> 32);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_resize_result want;
        if (!i_rst_n) begin
            resize_mode = iri_pkg::RST_MODE;
            src_width = iri_pkg::RST_DIM;
            src_height = iri_pkg::RST_DIM;
            col_step = iri_pkg::RST_STEP;
            row_step = iri_pkg::RST_STEP;
            pending_pixels.delete();
            o_fail_count = 0;
            o_pending = 0;
            o_checked = 0;
            o_range_errors = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    iri_pkg::CFG_RESIZE_MODE:   resize_mode = i_cfg_data[0];
                    iri_pkg::CFG_SOURCE_WIDTH:  src_width = i_cfg_data[iri_pkg::DIM_W-1:0];
                    iri_pkg::CFG_SOURCE_HEIGHT: src_height = i_cfg_data[iri_pkg::DIM_W-1:0];
                    iri_pkg::CFG_COLUMN_STEP:   col_step = i_cfg_data[iri_pkg::STEP_W-1:0];
                    iri_pkg::CFG_ROW_STEP:      row_step = i_cfg_data[iri_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end
            // retire before queuing: a compute accepted this edge cannot be the result now
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (i_range_error === 1'b1) o_range_errors++;
                if (pending_pixels.size() == 0) begin
                    $error("result with no compute transaction waiting: pixel_out %0d range_error %0d",
                           i_pixel_out, i_range_error);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (i_pixel_out !== want.pixel) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d",
                               want.pixel, i_pixel_out);
                        o_fail_count++;
                    end
                    if (i_range_error !== want.range_error) begin
                        $error("range_error mismatch: expected %0d, actual %0d",
                               want.range_error, i_range_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == iri_pkg::REQ_LOAD) begin
                    if (i_row_index < STORE_DIM && i_col_index < STORE_DIM)
                        src_pixels[i_row_index*STORE_DIM + i_col_index] = i_pixel_in;
                end else begin
                    pending_pixels.push_back(resample_pixel(i_row_index, i_col_index));
                end
            end
            o_pending = pending_pixels.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for image_resize_interpolator: clock, reset, stimulus and verdict.
// Drives the config, input and output-ready channels; checking lives in iri_checker.
// Depends on iri_pkg, iri_checker and the block RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DIM   = 256;
    localparam int MAX_GAP     = 13;
    localparam int IDLE_CYCLES = 40;
    localparam logic [iri_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [iri_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [iri_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           req_type = iri_pkg::REQ_LOAD;
    logic [iri_pkg::COORD_W-1:0]    row = '0;
    logic [iri_pkg::COORD_W-1:0]    col = '0;
    logic [iri_pkg::IN_PIX_W-1:0]   pix = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [iri_pkg::OUT_PIX_W-1:0]  pixel_out;
    logic                           range_error;

    int fail_count, pending, checked, range_errors;
    int n_loads = 0;
    int n_computes = 0;
    int n_settings = 0;
    bit no_gaps = 1'b0;
    bit loaded [STORE_DIM*STORE_DIM];

    // register values as last programmed, used to aim computes at loaded pixels
    logic [iri_pkg::DIM_W-1:0]  cur_w, cur_h;
    logic [iri_pkg::STEP_W-1:0] cur_cs, cur_rs;

    always #2 clk = ~clk;

    image_resize_interpolator uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_req_type    (req_type),
        .i_row_index   (row),
        .i_col_index   (col),
        .i_pixel_in    (pix),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_pixel_out   (pixel_out),
        .o_range_error (range_error)
    );

    iri_checker pixel_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_row_index    (row),
        .i_col_index    (col),
        .i_pixel_in     (pix),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_pixel_out    (pixel_out),
        .i_range_error  (range_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_range_errors (range_errors)
    );

    function automatic int unsigned clamp_dim(logic [iri_pkg::DIM_W-1:0] d);
        return (d > STORE_DIM) ? STORE_DIM : int'(d);
    endfunction

    // true when every pixel of the clamped 2x2 block the block may touch was loaded, or when out of range
    function automatic bit reads_loaded(logic [iri_pkg::COORD_W-1:0] r,
                                        logic [iri_pkg::COORD_W-1:0] c);
        logic [63:0] py, px;
        int unsigned w, h, y0, x0, y1, x1;
        w = clamp_dim(cur_w);
        h = clamp_dim(cur_h);
        py = 64'(r) * 64'(cur_rs);
        px = 64'(c) * 64'(cur_cs);
        if ((py >> 16) >= h || (px >> 16) >= w) return 1'b1;
        y0 = py[47:16];
        x0 = px[47:16];
        y1 = (y0 + 1 < h) ? y0 + 1 : y0;
        x1 = (x0 + 1 < w) ? x0 + 1 : x0;
        return loaded[y0*STORE_DIM + x0] && loaded[y0*STORE_DIM + x1] &&
               loaded[y1*STORE_DIM + x0] && loaded[y1*STORE_DIM + x1];
    endfunction

    // output coordinate landing on source position target plus a random fraction
    function automatic logic [iri_pkg::COORD_W-1:0] aim_coord(int unsigned target,
                                                              logic [iri_pkg::STEP_W-1:0] step);
        logic [63:0] v;
        if (step == 0) return iri_pkg::COORD_W'($urandom);
        v = ((64'(target) << 16) + 64'($urandom_range(0, 65535))) / 64'(step);
        return (v > 64'(4095)) ? '1 : v[iri_pkg::COORD_W-1:0];
    endfunction

    function automatic int unsigned pick_target(int unsigned dim);
        if (dim == 0) return 0;
        if ($urandom_range(0, 3) == 0) return dim - 1 - ((dim > 1) ? $urandom_range(0, 1) : 0);
        return $urandom_range(0, ((dim < 16) ? dim : 16) - 1);
    endfunction

    task automatic send_item(logic kind, logic [iri_pkg::COORD_W-1:0] r,
                             logic [iri_pkg::COORD_W-1:0] c,
                             logic [iri_pkg::IN_PIX_W-1:0] p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        row <= r;
        col <= c;
        pix <= p;
        do @(posedge clk); while (!in_ready);
        if (kind == iri_pkg::REQ_LOAD) begin
            n_loads++;
            if (r < STORE_DIM && c < STORE_DIM) loaded[r*STORE_DIM + c] = 1'b1;
        end else begin
            n_computes++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // trailing loads may still sit in the queue
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [iri_pkg::CFG_IDX_W-1:0] idx,
                             logic [iri_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic run_phase(logic mode, logic [iri_pkg::DIM_W-1:0] w,
                             logic [iri_pkg::DIM_W-1:0] h,
                             logic [iri_pkg::STEP_W-1:0] cs,
                             logic [iri_pkg::STEP_W-1:0] rs, int n);
        logic [iri_pkg::COORD_W-1:0] r, c;
        bit hit;
        wait_idle();
        write_reg(iri_pkg::CFG_RESIZE_MODE, iri_pkg::CFG_DATA_W'(mode));
        write_reg(iri_pkg::CFG_SOURCE_WIDTH, iri_pkg::CFG_DATA_W'(w));
        write_reg(iri_pkg::CFG_SOURCE_HEIGHT, iri_pkg::CFG_DATA_W'(h));
        write_reg(iri_pkg::CFG_COLUMN_STEP, iri_pkg::CFG_DATA_W'(cs));
        write_reg(iri_pkg::CFG_ROW_STEP, iri_pkg::CFG_DATA_W'(rs));
        write_reg(CFG_SPARE_IDX, iri_pkg::CFG_DATA_W'($urandom));  // unmapped, must be ignored
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
        cur_cs = cs;
        cur_rs = rs;
        n_settings++;
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            hit = 1'b0;
            if ($urandom_range(0, 4) != 0) begin
                for (int k = 0; k < 16 && !hit; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        r = iri_pkg::COORD_W'($urandom);
                        c = iri_pkg::COORD_W'($urandom);
                    end else begin
                        r = aim_coord(pick_target(clamp_dim(cur_h)), cur_rs);
                        c = aim_coord(pick_target(clamp_dim(cur_w)), cur_cs);
                    end
                    hit = reads_loaded(r, c);
                end
            end
            if (hit) begin
                send_item(iri_pkg::REQ_COMPUTE, r, c, iri_pkg::IN_PIX_W'($urandom));
            end else begin
                case ($urandom_range(0, 7))
                    0: begin
                        r = iri_pkg::COORD_W'($urandom);
                        c = iri_pkg::COORD_W'($urandom);
                    end
                    1: begin
                        r = iri_pkg::COORD_W'(STORE_DIM - 1 - $urandom_range(0, 7));
                        c = iri_pkg::COORD_W'(STORE_DIM - 1 - $urandom_range(0, 7));
                    end
                    default: begin
                        r = iri_pkg::COORD_W'($urandom_range(0, 15));
                        c = iri_pkg::COORD_W'($urandom_range(0, 15));
                    end
                endcase
                send_item(iri_pkg::REQ_LOAD, r, c, iri_pkg::IN_PIX_W'($urandom));
            end
        end
    endtask

    // result side: random stall before each transaction, none in burst phases
    initial begin
        int gap;
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        cur_w = iri_pkg::RST_DIM;
        cur_h = iri_pkg::RST_DIM;
        cur_cs = iri_pkg::RST_STEP;
        cur_rs = iri_pkg::RST_STEP;

        // reset settings: corners of the store, loads outside it, range errors
        send_item(iri_pkg::REQ_LOAD, 12'd0, 12'd0, 8'hFF);
        send_item(iri_pkg::REQ_LOAD, 12'd0, 12'd1, 8'h00);
        send_item(iri_pkg::REQ_LOAD, 12'd1, 12'd0, 8'h80);
        send_item(iri_pkg::REQ_LOAD, 12'd1, 12'd1, 8'h01);
        send_item(iri_pkg::REQ_LOAD, 12'd255, 12'd255, 8'hFF);
        send_item(iri_pkg::REQ_LOAD, 12'd255, 12'd254, 8'h7F);
        send_item(iri_pkg::REQ_LOAD, 12'd254, 12'd255, 8'h00);
        send_item(iri_pkg::REQ_LOAD, 12'd254, 12'd254, 8'hC3);
        send_item(iri_pkg::REQ_LOAD, 12'd256, 12'd3, 8'hFF);
        send_item(iri_pkg::REQ_LOAD, 12'd5, 12'd4095, 8'hFF);
        send_item(iri_pkg::REQ_LOAD, 12'd4095, 12'd4095, 8'hAA);
        send_item(iri_pkg::REQ_COMPUTE, 12'd0, 12'd0, 8'h00);
        send_item(iri_pkg::REQ_COMPUTE, 12'd254, 12'd254, 8'hFF);
        send_item(iri_pkg::REQ_COMPUTE, 12'd255, 12'd255, 8'h55);
        send_item(iri_pkg::REQ_COMPUTE, 12'd254, 12'd255, 8'h00);
        send_item(iri_pkg::REQ_COMPUTE, 12'd256, 12'd0, 8'h00);
        send_item(iri_pkg::REQ_COMPUTE, 12'd0, 12'd256, 8'h00);
        send_item(iri_pkg::REQ_COMPUTE, 12'd255, 12'd4095, 8'h00);
        send_item(iri_pkg::REQ_COMPUTE, 12'd4095, 12'd4095, 8'h00);

        // fill a small window so later computes have neighbors to read
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                send_item(iri_pkg::REQ_LOAD, iri_pkg::COORD_W'(y), iri_pkg::COORD_W'(x),
                          iri_pkg::IN_PIX_W'($urandom));

        run_phase(iri_pkg::MODE_BILINEAR, 9'd256, 9'd256, 25'h0008000, 25'h0008000, 80);
        run_phase(iri_pkg::MODE_NEAREST, 9'd8, 9'd8, 25'h0010000, 25'h0010000, 70);
        run_phase(iri_pkg::MODE_BILINEAR, 9'd1, 9'd1, 25'h0004000, 25'h0004000, 60);
        run_phase(iri_pkg::MODE_BILINEAR, 9'd511, 9'd300, 25'h0018000, 25'h000C000, 80);
        run_phase(iri_pkg::MODE_NEAREST, 9'd0, 9'd5, 25'h0010000, 25'h0010000, 40);
        run_phase(iri_pkg::MODE_BILINEAR, 9'd8, 9'd8, 25'h0000000, 25'h0000000, 60);
        run_phase(iri_pkg::MODE_BILINEAR, 9'd256, 9'd256, 25'h1000000, 25'h1FFFFFF, 50);
        run_phase(iri_pkg::MODE_NEAREST, 9'd256, 9'd256, 25'h1FFFFFF, 25'h1000000, 50);
        run_phase(iri_pkg::MODE_BILINEAR, 9'd5, 9'd3, 25'h0005555, 25'h0009999, 80);
        run_phase(iri_pkg::MODE_NEAREST, 9'd16, 9'd16, 25'h000A000, 25'h0014000, 70);
        repeat (5) begin
            run_phase(logic'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0) ? iri_pkg::DIM_W'($urandom_range(1, 256))
                                                  : iri_pkg::DIM_W'($urandom_range(1, 16)),
                      ($urandom_range(0, 3) == 0) ? iri_pkg::DIM_W'($urandom_range(1, 256))
                                                  : iri_pkg::DIM_W'($urandom_range(1, 16)),
                      iri_pkg::STEP_W'($urandom_range(32'h2000, 32'h40000)),
                      iri_pkg::STEP_W'($urandom_range(32'h2000, 32'h40000)), 80);
        end
        wait_idle();

        $display("Ran %0d loads and %0d computes over %0d register settings.",
                 n_loads, n_computes, n_settings);
        $display("Compared %0d results, %0d of them flagged out of range.",
                 checked, range_errors);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
